@@ rtl/uer_pkg.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Function codes, register indexes, reset values and the constants used for
// converting an echo width to centimeters.
// ----------------------------------------------------------------------------
package uer_pkg;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_ECHO  = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_FETCH = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_TIMEOUT_MS   = 2'd0,
        REG_MIN_VALID_US = 2'd1,
        REG_MAX_VALID_US = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    localparam int unsigned CFG_W      = 16;
    localparam int unsigned DIST_W     = 11;
    localparam int unsigned MS_W       = 32;

    localparam logic [CFG_W-1:0] TIMEOUT_MS_RST   = 16'd35;
    localparam logic [CFG_W-1:0] MIN_VALID_US_RST = 16'd100;
    localparam logic [CFG_W-1:0] MAX_VALID_US_RST = 16'd25000;

    // Division of a 16-bit width by 58: multiply by ceil(2^23 / 58) and keep
    // the bits above 2^23. The rounding error stays below one quotient step
    // over the whole 16-bit range.
    localparam int unsigned     DIV_SHIFT = 23;
    localparam int unsigned     RECIP_W   = 18;
    localparam logic [RECIP_W-1:0] RECIP_58 = 18'd144632;
    localparam int unsigned     PROD_W    = CFG_W + RECIP_W;

endpackage

@@ rtl/ultrasonic_echo_ranger.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Start, echo edge, tick and fetch items drive the ranging state; each item
// yields one result item through a registered output stage.
// ----------------------------------------------------------------------------
// The result of an item is registered and valid in the cycle after its transfer.
// Throughput: one item per cycle; the output register takes a new result in
// the cycle the previous one is taken, so ready drops only on a held result.
// Reset: aresetn clears the ranging flags, the stored times and the output
// valid flag, and loads timeout 35 ms and a valid window of 100 to 25000 us.
module ultrasonic_echo_ranger #(
    parameter int US_COUNTER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic        s_echo_level,
    input  logic [15:0] s_time_us,
    input  logic [31:0] s_now_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_trigger_fire,
    output logic        m_busy_res,
    output logic        m_got_event,
    output logic        m_range_valid,
    output logic [10:0] m_range_cm
);

    localparam int CMP_W = (US_COUNTER_BITS > 16) ? US_COUNTER_BITS : 16;

    // Configuration registers
    logic [15:0] timeout_ms_reg;
    logic [15:0] min_valid_us_reg;
    logic [15:0] max_valid_us_reg;

    // Ranging state
    logic                       busy_reg, busy_next;
    logic                       await_fall_reg, await_fall_next;
    logic                       result_ready_reg, result_ready_next;
    logic                       timed_out_reg, timed_out_next;
    logic [US_COUNTER_BITS-1:0] echo_start_reg, echo_start_next;
    logic [US_COUNTER_BITS-1:0] echo_width_reg, echo_width_next;
    logic [31:0]                trig_time_reg, trig_time_next;

    // Output register
    logic        m_valid_reg;
    logic        fire_reg, fire_next;
    logic        busy_res_reg;
    logic        got_reg, got_next;
    logic        has_reg, has_next;
    logic [10:0] dist_reg, dist_next;

    logic                       in_xfer;
    logic [31:0]                t_ext;
    logic [US_COUNTER_BITS-1:0] t_us;
    logic [31:0]                elapsed_ms;
    logic [CMP_W-1:0]           width_cmp;
    logic                       width_ok;
    logic [uer_pkg::PROD_W-1:0] dist_prod;
    uer_pkg::func_t             func;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_xfer   = s_valid && s_ready;
    assign func      = uer_pkg::func_t'(s_func);

    assign t_ext      = {16'd0, s_time_us};
    assign t_us       = t_ext[US_COUNTER_BITS-1:0];
    assign elapsed_ms = s_now_ms - trig_time_reg;

    assign width_cmp = CMP_W'(echo_width_reg);
    assign width_ok  = (width_cmp >= CMP_W'(min_valid_us_reg))
                    && (width_cmp <= CMP_W'(max_valid_us_reg));
    // A valid width never exceeds the 16-bit window limit.
    assign dist_prod = width_cmp[15:0] * uer_pkg::RECIP_58;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ms_reg   <= uer_pkg::TIMEOUT_MS_RST;
            min_valid_us_reg <= uer_pkg::MIN_VALID_US_RST;
            max_valid_us_reg <= uer_pkg::MAX_VALID_US_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (uer_pkg::reg_index_t'(cfg_index))
                uer_pkg::REG_TIMEOUT_MS:   timeout_ms_reg   <= cfg_data;
                uer_pkg::REG_MIN_VALID_US: min_valid_us_reg <= cfg_data;
                uer_pkg::REG_MAX_VALID_US: max_valid_us_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        busy_next         = busy_reg;
        await_fall_next   = await_fall_reg;
        result_ready_next = result_ready_reg;
        timed_out_next    = timed_out_reg;
        echo_start_next   = echo_start_reg;
        echo_width_next   = echo_width_reg;
        trig_time_next    = trig_time_reg;
        fire_next         = 1'b0;
        got_next          = 1'b0;
        has_next          = 1'b0;
        dist_next         = '0;

        unique case (func)
            uer_pkg::FUNC_START: begin
                if (!busy_reg) begin
                    busy_next         = 1'b1;
                    await_fall_next   = 1'b0;
                    result_ready_next = 1'b0;
                    timed_out_next    = 1'b0;
                    trig_time_next    = s_now_ms;
                    fire_next         = 1'b1;
                end
            end
            uer_pkg::FUNC_ECHO: begin
                if (busy_reg) begin
                    if (!await_fall_reg) begin
                        if (s_echo_level) begin
                            echo_start_next = t_us;
                            await_fall_next = 1'b1;
                        end
                    end else if (!s_echo_level) begin
                        // Modular subtraction handles a counter wrap.
                        echo_width_next   = t_us - echo_start_reg;
                        busy_next         = 1'b0;
                        result_ready_next = 1'b1;
                    end
                end
            end
            uer_pkg::FUNC_TICK: begin
                if (busy_reg && (elapsed_ms >= {16'd0, timeout_ms_reg})) begin
                    busy_next      = 1'b0;
                    timed_out_next = 1'b1;
                end
            end
            uer_pkg::FUNC_FETCH: begin
                if (result_ready_reg) begin
                    result_ready_next = 1'b0;
                    got_next          = 1'b1;
                    if (width_ok) begin
                        has_next  = 1'b1;
                        dist_next = dist_prod[uer_pkg::DIV_SHIFT +: uer_pkg::DIST_W];
                    end
                end else if (timed_out_reg) begin
                    timed_out_next = 1'b0;
                    got_next       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= 1'b0;
            await_fall_reg   <= 1'b0;
            result_ready_reg <= 1'b0;
            timed_out_reg    <= 1'b0;
            echo_start_reg   <= '0;
            echo_width_reg   <= '0;
            trig_time_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (in_xfer) begin
                busy_reg         <= busy_next;
                await_fall_reg   <= await_fall_next;
                result_ready_reg <= result_ready_next;
                timed_out_reg    <= timed_out_next;
                echo_start_reg   <= echo_start_next;
                echo_width_reg   <= echo_width_next;
                trig_time_reg    <= trig_time_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            fire_reg     <= fire_next;
            busy_res_reg <= busy_next;
            got_reg      <= got_next;
            has_reg      <= has_next;
            dist_reg     <= dist_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_trigger_fire = fire_reg;
    assign m_busy_res     = busy_res_reg;
    assign m_got_event    = got_reg;
    assign m_range_valid  = has_reg;
    assign m_range_cm     = dist_reg;

endmodule

@@ rtl/uer_checker.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module uer_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_trigger_fire,
    input logic        m_busy_res,
    input logic        m_got_event,
    input logic        m_range_valid,
    input logic [10:0] m_range_cm
);

    // A held result keeps its payload until the transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_range_cm)
            && $stable(m_got_event) && $stable(m_range_valid))
        else $error("result changed while stalled");

    // A fired trigger always leaves a measurement running.
    a_fire_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_trigger_fire |-> m_busy_res && !m_got_event)
        else $error("trigger without busy");

    // A distance only comes with a consumed event.
    a_dist_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_valid |-> m_got_event)
        else $error("distance without event");

    // Without a distance the distance field reads zero.
    a_dist_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_range_valid |-> m_range_cm == 11'd0)
        else $error("nonzero distance without valid width");

    // The valid window is at most 65535 us, so the distance stays in range.
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_valid |-> m_range_cm <= 11'd1129)
        else $error("distance out of range");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_trigger_fire (m_trigger_fire),
    .m_busy_res     (m_busy_res),
    .m_got_event    (m_got_event),
    .m_range_valid  (m_range_valid),
    .m_range_cm     (m_range_cm)
);

@@ tb/ultrasonic_echo_ranger_tb.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger testbench
// Drives start, echo edge, tick and fetch items through the input channel
// and compares every result with a cycle-free model of the ranging state.
// Directed cases cover idle and busy corners, counter and millisecond wrap,
// and window edges; random phases run measurement and timeout sequences
// under several register settings with random gaps on both channels.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;

    localparam int unsigned CLK_PERIOD       = 12;
    localparam int unsigned RUN_LIMIT_CYCLES = 1_500_000;
    localparam int unsigned US_PER_CM        = 58;

    typedef struct packed {
        logic                       trigger_fire;
        logic                       busy;
        logic                       got_event;
        logic                       range_valid;
        logic [uer_pkg::DIST_W-1:0] range_cm;
    } echo_report_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [15:0]       cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_func;
    logic              s_echo_level;
    logic [15:0]       s_time_us;
    logic [31:0]       s_now_ms;
    logic              m_valid;
    logic              m_ready;
    logic              m_trigger_fire;
    logic              m_busy_res;
    logic              m_got_event;
    logic              m_range_valid;
    logic [10:0]       m_range_cm;

    // Model of the ranging state and its registers.
    logic [uer_pkg::CFG_W-1:0] rg_timeout_ms;
    logic [uer_pkg::CFG_W-1:0] rg_min_us;
    logic [uer_pkg::CFG_W-1:0] rg_max_us;
    logic                      rg_busy;
    logic                      rg_await_fall;
    logic                      rg_ready;
    logic                      rg_timed_out;
    logic [15:0]               rg_start_us;
    logic [15:0]               rg_width_us;
    logic [uer_pkg::MS_W-1:0]  rg_trigger_ms;

    echo_report_t      echo_reports[$];
    int unsigned       mismatches;
    int unsigned       items_sent;
    logic              tx_steady;
    logic              rx_steady;

    ultrasonic_echo_ranger u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_echo_level   (s_echo_level),
        .s_time_us      (s_time_us),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_trigger_fire (m_trigger_fire),
        .m_busy_res     (m_busy_res),
        .m_got_event    (m_got_event),
        .m_range_valid  (m_range_valid),
        .m_range_cm     (m_range_cm)
    );

    always begin
        aclk = 1'b0;
        #(CLK_PERIOD / 2);
        aclk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        else if (roll < 88) return $urandom_range(1, 3);
        else if (roll < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    function automatic echo_report_t advance_ranger(uer_pkg::func_t f, logic lvl,
                                                    logic [15:0] t_us,
                                                    logic [uer_pkg::MS_W-1:0] now);
        echo_report_t             r;
        logic [uer_pkg::MS_W-1:0] elapsed;
        logic [15:0]              quotient;
        r = '0;
        case (f)
            uer_pkg::FUNC_START: begin
                if (!rg_busy) begin
                    rg_busy       = 1'b1;
                    rg_await_fall = 1'b0;
                    rg_ready      = 1'b0;
                    rg_timed_out  = 1'b0;
                    rg_trigger_ms = now;
                    r.trigger_fire = 1'b1;
                end
            end
            uer_pkg::FUNC_ECHO: begin
                if (rg_busy) begin
                    if (!rg_await_fall) begin
                        if (lvl) begin
                            rg_start_us   = t_us;
                            rg_await_fall = 1'b1;
                        end
                    end else if (!lvl) begin
                        rg_width_us = t_us - rg_start_us;
                        rg_busy     = 1'b0;
                        rg_ready    = 1'b1;
                    end
                end
            end
            uer_pkg::FUNC_TICK: begin
                elapsed = now - rg_trigger_ms;
                if (rg_busy && elapsed >= {16'd0, rg_timeout_ms}) begin
                    rg_busy      = 1'b0;
                    rg_timed_out = 1'b1;
                end
            end
            default: begin
                // A ready result always wins over a pending timeout.
                if (rg_ready) begin
                    rg_ready    = 1'b0;
                    r.got_event = 1'b1;
                    if (rg_width_us >= rg_min_us && rg_width_us <= rg_max_us) begin
                        quotient      = 16'(rg_width_us / US_PER_CM);
                        r.range_valid = 1'b1;
                        r.range_cm    = quotient[uer_pkg::DIST_W-1:0];
                    end
                end else if (rg_timed_out) begin
                    rg_timed_out = 1'b0;
                    r.got_event  = 1'b1;
                end
            end
        endcase
        r.busy = rg_busy;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        echo_report_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (echo_reports.size() == 0) begin
                $error("result transfer with no pending expectation");
                mismatches++;
            end else begin
                want = echo_reports.pop_front();
                check_field("trigger_fire", want.trigger_fire, m_trigger_fire);
                check_field("busy_res", want.busy, m_busy_res);
                check_field("got_event", want.got_event, m_got_event);
                check_field("range_valid", want.range_valid, m_range_valid);
                check_field("range_cm", want.range_cm, m_range_cm);
            end
        end
    end

    // Result side: ready bursts broken by stalls, unless held steady.
    initial begin : result_sink
        int hold;
        int gap;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 20);
            m_ready = 1'b1;
            repeat (hold) @(negedge aclk);
            gap = rx_steady ? 0 : pick_gap();
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    end

    task automatic send_item(uer_pkg::func_t f, logic lvl, logic [15:0] t_us,
                             logic [uer_pkg::MS_W-1:0] now);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_func       = f;
        s_echo_level = lvl;
        s_time_us    = t_us;
        s_now_ms     = now;
        s_valid      = 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        echo_reports.push_back(advance_ranger(f, lvl, t_us, now));
        items_sent++;
    endtask

    // Hold the sender off until every result has been taken.
    task automatic wait_reports_done();
        @(negedge aclk);
        s_valid = 1'b0;
        while (echo_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(uer_pkg::reg_index_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            uer_pkg::REG_TIMEOUT_MS:   rg_timeout_ms = val;
            uer_pkg::REG_MIN_VALID_US: rg_min_us     = val;
            uer_pkg::REG_MAX_VALID_US: rg_max_us     = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(logic [15:0] tmo, logic [15:0] lo, logic [15:0] hi);
        wait_reports_done();
        write_reg(uer_pkg::REG_TIMEOUT_MS, tmo);
        write_reg(uer_pkg::REG_MIN_VALID_US, lo);
        write_reg(uer_pkg::REG_MAX_VALID_US, hi);
    endtask

    task automatic measure(logic [uer_pkg::MS_W-1:0] now, logic [15:0] t0,
                           logic [15:0] width);
        send_item(uer_pkg::FUNC_START, 1'b0, 16'd0, now);
        send_item(uer_pkg::FUNC_ECHO, 1'b1, t0, 32'd0);
        send_item(uer_pkg::FUNC_ECHO, 1'b0, t0 + width, 32'd0);
        send_item(uer_pkg::FUNC_FETCH, 1'b0, 16'd0, 32'd0);
    endtask

    function automatic logic [15:0] pick_width();
        case ($urandom_range(0, 7))
            0: return rg_min_us - 16'd1;
            1: return rg_min_us;
            2: return rg_max_us;
            3: return rg_max_us + 16'd1;
            4: return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
            5: return 16'($urandom_range(rg_min_us, rg_max_us));
            default: return 16'($urandom);
        endcase
    endfunction

    // A well-formed measurement with random content and occasional stray items.
    task automatic measure_seq();
        logic [uer_pkg::MS_W-1:0] now;
        logic [15:0]              t0;
        logic [15:0]              width;
        now   = $urandom;
        t0    = 16'($urandom);
        width = pick_width();
        send_item(uer_pkg::FUNC_START, 1'($urandom), 16'($urandom), now);
        if ($urandom_range(0, 3) == 0)
            send_item(uer_pkg::FUNC_ECHO, 1'b0, 16'($urandom), $urandom);
        if ($urandom_range(0, 4) == 0)
            send_item(uer_pkg::FUNC_START, 1'($urandom), 16'($urandom), $urandom);
        if ($urandom_range(0, 5) == 0)
            send_item(uer_pkg::FUNC_TICK, 1'($urandom), 16'($urandom),
                      now + $urandom_range(0, 40));
        send_item(uer_pkg::FUNC_ECHO, 1'b1, t0, $urandom);
        if ($urandom_range(0, 3) == 0)
            send_item(uer_pkg::FUNC_ECHO, 1'b1, 16'($urandom), $urandom);
        send_item(uer_pkg::FUNC_ECHO, 1'b0, t0 + width, $urandom);
        send_item(uer_pkg::FUNC_FETCH, 1'($urandom), 16'($urandom), $urandom);
        if ($urandom_range(0, 3) == 0)
            send_item(uer_pkg::FUNC_FETCH, 1'($urandom), 16'($urandom), $urandom);
    endtask

    // Start, ticks around the timeout boundary, then fetch.
    task automatic timeout_seq();
        logic [uer_pkg::MS_W-1:0] now;
        logic [uer_pkg::MS_W-1:0] tmo;
        int                       ticks;
        now   = $urandom;
        tmo   = {16'd0, rg_timeout_ms};
        ticks = $urandom_range(0, 2);
        send_item(uer_pkg::FUNC_START, 1'($urandom), 16'($urandom), now);
        repeat (ticks)
            send_item(uer_pkg::FUNC_TICK, 1'($urandom), 16'($urandom),
                      now + $urandom_range(0, tmo));
        if ($urandom_range(0, 1) == 0)
            send_item(uer_pkg::FUNC_TICK, 1'($urandom), 16'($urandom), now + tmo - 32'd1);
        send_item(uer_pkg::FUNC_TICK, 1'($urandom), 16'($urandom),
                  now + tmo + $urandom_range(0, 3));
        send_item(uer_pkg::FUNC_FETCH, 1'($urandom), 16'($urandom), $urandom);
        if ($urandom_range(0, 2) == 0)
            send_item(uer_pkg::FUNC_FETCH, 1'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic run_traffic(int unsigned count);
        int unsigned first;
        int          roll;
        first = items_sent;
        while (items_sent - first < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) measure_seq();
            else if (roll < 75) timeout_seq();
            else if (roll < 97)
                send_item(uer_pkg::func_t'($urandom_range(0, 3)), 1'($urandom),
                          16'($urandom), $urandom);
            else wait_reports_done();
        end
    endtask

    task automatic test_reset_values();
        send_item(uer_pkg::FUNC_FETCH, 1'b0, 16'd0, 32'd0);
        send_item(uer_pkg::FUNC_TICK, 1'b0, 16'd0, 32'hFFFF_FFFF);
        send_item(uer_pkg::FUNC_ECHO, 1'b1, 16'hFFFF, 32'd0);
        measure(32'd0, 16'd0, 16'd5800);
    endtask

    task automatic test_corner_cases();
        // Second start while busy, low before any rise, high while awaiting fall.
        send_item(uer_pkg::FUNC_START, 1'b1, 16'hFFFF, 32'h1234_5678);
        send_item(uer_pkg::FUNC_START, 1'b0, 16'd0, 32'hFFFF_FFFF);
        send_item(uer_pkg::FUNC_ECHO, 1'b0, 16'd10, 32'd0);
        send_item(uer_pkg::FUNC_ECHO, 1'b1, 16'd65000, 32'd0);
        send_item(uer_pkg::FUNC_ECHO, 1'b1, 16'd20, 32'd0);
        // The microsecond counter wraps between the edges.
        send_item(uer_pkg::FUNC_ECHO, 1'b0, 16'd1000, 32'd0);
        send_item(uer_pkg::FUNC_FETCH, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(uer_pkg::FUNC_FETCH, 1'b0, 16'd0, 32'd0);
        measure(32'd7, 16'd300, 16'd25000);
        // Millisecond wrap: elapsed 34 stays busy, elapsed 35 times out.
        send_item(uer_pkg::FUNC_START, 1'b0, 16'd0, 32'hFFFF_FFF0);
        send_item(uer_pkg::FUNC_TICK, 1'b0, 16'd0, 32'h0000_0012);
        send_item(uer_pkg::FUNC_TICK, 1'b0, 16'd0, 32'h0000_0013);
        send_item(uer_pkg::FUNC_FETCH, 1'b0, 16'd0, 32'd0);
    endtask

    task automatic test_config_extremes();
        apply_settings(16'd0, 16'd0, 16'hFFFF);
        measure(32'd0, 16'd0, 16'hFFFF);
        send_item(uer_pkg::FUNC_START, 1'b0, 16'd0, 32'h8000_0000);
        send_item(uer_pkg::FUNC_TICK, 1'b0, 16'd0, 32'h8000_0000);
        send_item(uer_pkg::FUNC_FETCH, 1'b0, 16'd0, 32'd0);
        // Minimum above maximum leaves no valid width at all.
        apply_settings(16'd1, 16'd500, 16'd400);
        measure(32'd3, 16'd123, 16'd450);
        wait_reports_done();
        write_reg(uer_pkg::REG_UNUSED, 16'($urandom));
    endtask

    task automatic test_random_phases();
        logic [15:0] tmo_set[8];
        logic [15:0] lo_set[8];
        logic [15:0] hi_set[8];
        tmo_set = '{uer_pkg::TIMEOUT_MS_RST, 16'd0, 16'hFFFF, 16'd1, 16'd20,
                    16'd0, 16'd0, 16'd0};
        lo_set  = '{uer_pkg::MIN_VALID_US_RST, 16'd0, 16'd0, 16'hFFFF, 16'd30000,
                    16'd0, 16'd0, 16'd0};
        hi_set  = '{uer_pkg::MAX_VALID_US_RST, 16'hFFFF, 16'd0, 16'hFFFF, 16'd100,
                    16'd0, 16'd0, 16'd0};
        for (int i = 5; i < 8; i++) begin
            tmo_set[i] = 16'($urandom_range(1, 200));
            lo_set[i]  = 16'($urandom);
            hi_set[i]  = 16'($urandom);
        end
        foreach (tmo_set[i]) begin
            apply_settings(tmo_set[i], lo_set[i], hi_set[i]);
            run_traffic(190);
        end
    endtask

    task automatic test_full_rate();
        apply_settings(16'($urandom_range(1, 100)), 16'($urandom_range(0, 2000)),
                       16'($urandom_range(20000, 65535)));
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_traffic(150);
        wait_reports_done();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = uer_pkg::REG_TIMEOUT_MS;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_func        = uer_pkg::FUNC_START;
        s_echo_level  = 1'b0;
        s_time_us     = '0;
        s_now_ms      = '0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        mismatches    = 0;
        items_sent    = 0;
        rg_timeout_ms = uer_pkg::TIMEOUT_MS_RST;
        rg_min_us     = uer_pkg::MIN_VALID_US_RST;
        rg_max_us     = uer_pkg::MAX_VALID_US_RST;
        rg_busy       = 1'b0;
        rg_await_fall = 1'b0;
        rg_ready      = 1'b0;
        rg_timed_out  = 1'b0;
        rg_start_us   = '0;
        rg_width_us   = '0;
        rg_trigger_ms = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_values();
        test_corner_cases();
        test_config_extremes();
        test_random_phases();
        test_full_rate();
        wait_reports_done();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
rtl/uer_pkg.sv
rtl/ultrasonic_echo_ranger.sv
rtl/uer_checker.sv
tb/ultrasonic_echo_ranger_tb.sv
